// File: src/vct_pkg.sv
// ============================================================================
// vct_pkg: shared types and constants for the stream socket connection table
// Holds the request and response structures and the opcode and action codes.
// ============================================================================
package vct_pkg;

   localparam int unsigned MaxConnections = 64;
   localparam logic [11:0] PayloadCap     = 12'd4000;
   localparam logic [31:0] FirstHostPort  = 32'd50000;
   localparam logic [31:0] BufReset       = 32'd262144;

   localparam logic [1:0] OP_GUEST   = 2'd0;
   localparam logic [1:0] OP_HDATA   = 2'd1;
   localparam logic [1:0] OP_HCLOSE  = 2'd2;

   localparam logic [15:0] PK_REQUEST        = 16'd1;
   localparam logic [15:0] PK_RESPONSE       = 16'd2;
   localparam logic [15:0] PK_RST            = 16'd3;
   localparam logic [15:0] PK_SHUTDOWN       = 16'd4;
   localparam logic [15:0] PK_DATA           = 16'd5;
   localparam logic [15:0] PK_CREDIT_REQUEST = 16'd7;
   localparam logic [15:0] PK_CREDIT_UPDATE  = 16'd6;

   localparam logic [2:0] ACT_NONE  = 3'd0;
   localparam logic [2:0] ACT_WRITE = 3'd1;
   localparam logic [2:0] ACT_OK    = 3'd2;
   localparam logic [2:0] ACT_CLOSE = 3'd3;
   localparam logic [2:0] ACT_READ  = 3'd4;

   localparam logic [0:0] REG_MAX_PAYLOAD = 1'b0;
   localparam logic [0:0] REG_ADV_BUFFER  = 1'b1;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] pkt_op;
      logic [31:0] vm_port;
      logic [31:0] hv_port;
      logic [31:0] len;
      logic [31:0] rx_buf_size;
      logic [31:0] fwd_cnt;
      logic        host_ok;
      logic [11:0] host_bytes;
   } req_type;

   typedef struct packed {
      logic        send_valid;
      logic [2:0]  send_op;
      logic [31:0] send_host_port;
      logic [31:0] send_guest_port;
      logic [11:0] send_len;
      logic [1:0]  send_flags;
      logic [31:0] send_fwd_cnt;
      logic [31:0] send_buf_alloc;
      logic [2:0]  host_action;
      logic [31:0] host_len;
   } rsp_type;

   typedef struct packed {
      logic [31:0] vm_port;
      logic [31:0] hv_port;
      logic [31:0] rx_count;
      logic [31:0] tx_count;
      logic [31:0] peer_buffer;
      logic [31:0] peer_forwarded;
   } entry_type;

endpackage

// File: src/vsock_connection_table_top.sv
// ============================================================================
// vsock_connection_table_top: connection table with credit flow control
// Finds or allocates connections and answers each event with one response.
// ============================================================================
// Usage: requests arrive on req_ (valid/ready) carrying one event each: a
// guest packet, host data ready, host stream closed or a host connect. Every
// request produces exactly one response on rsp_, holding at most one packet
// to the guest and one host-side action.
// The block handles one request at a time. The
// entry memory is scanned one entry per cycle to find the matching
// connection and the lowest free entry before the request is executed.
// The result sits in an output register; req_ready rises the cycle after it
// has been taken, so no new request is taken while one is in flight, and
// while it waits the receiver may stall for as long as it likes.
// Reset clears every used flag, sets the next host port to 50000 and the
// registers to their defaults. Entry contents need no clearing because an
// entry is always fully written when it is allocated.
// csr_ is an APB-style port: max_payload at 0x0, advertised_buffer at 0x4.
// ============================================================================
module vsock_connection_table_top #(
   parameter int unsigned MAX_CONNECTIONS = vct_pkg::MaxConnections
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  vct_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output vct_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import vct_pkg::*;

   localparam int unsigned IW = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;
   localparam int unsigned CW = $clog2(MAX_CONNECTIONS + 1);

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_RDENT, S_EXEC, S_OUT} state_type;

   state_type   state_ff;
   req_type     req_ff;
   rsp_type     rsp_ff;
   logic [11:0] max_payload_ff;
   logic [31:0] adv_buffer_ff;
   logic [31:0] next_hp_ff;

   // Used and phase flags are per-entry flip-flops; the payload lives in memory.
   logic [MAX_CONNECTIONS-1:0] used_ff;
   logic [MAX_CONNECTIONS-1:0] phase_ff;
   entry_type                  mem [MAX_CONNECTIONS];
   entry_type                  rd_ff;

   logic [CW-1:0] scan_ff;
   logic [IW-1:0] rd_idx_ff;
   logic          hit_ff;
   logic [IW-1:0] hit_idx_ff;
   logic          free_ff;
   logic [IW-1:0] free_idx_ff;
   logic          cmp_valid_ff;
   logic [IW-1:0] cmp_idx_ff;

   logic          csr_wr;
   logic [11:0]   lim;
   logic [31:0]   inflight;
   logic [31:0]   credit;
   logic [31:0]   chunk;
   logic [31:0]   rx_sum;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   always_comb begin
      unique case (csr_paddr[2])
         REG_MAX_PAYLOAD: csr_prdata = {20'd0, max_payload_ff};
         default:         csr_prdata = adv_buffer_ff;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = rsp_ff;

   // Credit and chunk for host data on the found entry.
   assign lim      = (max_payload_ff > PayloadCap) ? PayloadCap : max_payload_ff;
   assign inflight = rd_ff.tx_count - rd_ff.peer_forwarded;
   assign credit   = (rd_ff.peer_buffer > inflight) ? rd_ff.peer_buffer - inflight : 32'd0;
   always_comb begin
      chunk = {20'd0, req_ff.host_bytes};
      if (chunk > credit) chunk = credit;
      if (chunk > {20'd0, lim}) chunk = {20'd0, lim};
   end
   assign rx_sum = rd_ff.rx_count + req_ff.len;

   always_ff @(posedge clock) begin
      if (state_ff == S_SCAN && scan_ff < CW'(MAX_CONNECTIONS)) begin
         rd_ff <= mem[scan_ff[IW-1:0]];
      end else if (state_ff == S_RDENT) begin
         rd_ff <= mem[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         max_payload_ff <= PayloadCap;
         adv_buffer_ff  <= BufReset;
         next_hp_ff     <= FirstHostPort;
         used_ff        <= '0;
         phase_ff       <= '0;
         scan_ff        <= '0;
         cmp_valid_ff   <= 1'b0;
         hit_ff         <= 1'b0;
         free_ff        <= 1'b0;
      end else begin
         if (csr_wr) begin
            unique case (csr_paddr[2])
               REG_MAX_PAYLOAD: max_payload_ff <= csr_pwdata[11:0];
               default:         adv_buffer_ff  <= csr_pwdata;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff       <= req_data;
                  rsp_ff       <= '0;
                  state_ff     <= S_SCAN;
                  scan_ff      <= '0;
                  cmp_valid_ff <= 1'b0;
                  hit_ff       <= 1'b0;
                  free_ff      <= 1'b0;
               end
            end
            S_SCAN: begin
               // One memory read per cycle; the compare runs in the cycle after each read.
               if (cmp_valid_ff && !hit_ff && used_ff[cmp_idx_ff] &&
                   rd_ff.vm_port == req_ff.vm_port &&
                   rd_ff.hv_port == req_ff.hv_port) begin
                  hit_ff     <= 1'b1;
                  hit_idx_ff <= cmp_idx_ff;
               end
               if (cmp_valid_ff && !free_ff && !used_ff[cmp_idx_ff]) begin
                  free_ff     <= 1'b1;
                  free_idx_ff <= cmp_idx_ff;
               end
               if (scan_ff < CW'(MAX_CONNECTIONS)) begin
                  cmp_valid_ff <= 1'b1;
                  cmp_idx_ff   <= scan_ff[IW-1:0];
                  scan_ff      <= scan_ff + 1'b1;
               end else begin
                  cmp_valid_ff <= 1'b0;
                  state_ff     <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               rd_idx_ff <= hit_idx_ff;
               state_ff  <= S_RDENT;
            end
            S_RDENT: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               state_ff <= S_OUT;
               if (req_ff.op == OP_GUEST) begin
                  if (hit_ff) begin
                     mem[hit_idx_ff] <= '{vm_port: rd_ff.vm_port,
                                          hv_port: rd_ff.hv_port,
                                          rx_count: (req_ff.pkt_op == PK_DATA) ? rx_sum
                                                    : rd_ff.rx_count,
                                          tx_count: rd_ff.tx_count,
                                          peer_buffer: req_ff.rx_buf_size,
                                          peer_forwarded: req_ff.fwd_cnt};
                  end
                  case (req_ff.pkt_op)
                     PK_REQUEST: begin
                        if (!hit_ff) begin
                           rsp_ff.send_valid      <= 1'b1;
                           rsp_ff.send_host_port  <= req_ff.hv_port;
                           rsp_ff.send_guest_port <= req_ff.vm_port;
                           rsp_ff.send_buf_alloc  <= adv_buffer_ff;
                           if (!free_ff || !req_ff.host_ok) begin
                              rsp_ff.send_op <= PK_RST[2:0];
                           end else begin
                              rsp_ff.send_op        <= PK_RESPONSE[2:0];
                              used_ff[free_idx_ff]  <= 1'b1;
                              phase_ff[free_idx_ff] <= 1'b0;
                              mem[free_idx_ff] <= '{vm_port: req_ff.vm_port,
                                                   hv_port: req_ff.hv_port,
                                                   rx_count: 32'd0, tx_count: 32'd0,
                                                   peer_buffer: req_ff.rx_buf_size,
                                                   peer_forwarded: req_ff.fwd_cnt};
                           end
                        end
                     end
                     PK_RESPONSE: begin
                        if (hit_ff && phase_ff[hit_idx_ff]) begin
                           phase_ff[hit_idx_ff] <= 1'b0;
                           rsp_ff.host_action   <= ACT_OK;
                        end
                     end
                     PK_DATA: begin
                        rsp_ff.send_valid     <= 1'b1;
                        rsp_ff.send_buf_alloc <= adv_buffer_ff;
                        if (!hit_ff) begin
                           rsp_ff.send_op         <= PK_RST[2:0];
                           rsp_ff.send_host_port  <= req_ff.hv_port;
                           rsp_ff.send_guest_port <= req_ff.vm_port;
                        end else begin
                           rsp_ff.send_op         <= PK_CREDIT_UPDATE[2:0];
                           rsp_ff.send_host_port  <= rd_ff.hv_port;
                           rsp_ff.send_guest_port <= rd_ff.vm_port;
                           rsp_ff.send_fwd_cnt    <= rx_sum;
                           rsp_ff.host_action     <= ACT_WRITE;
                           rsp_ff.host_len        <= req_ff.len;
                        end
                     end
                     PK_CREDIT_REQUEST: begin
                        if (hit_ff) begin
                           rsp_ff.send_valid      <= 1'b1;
                           rsp_ff.send_op         <= PK_CREDIT_UPDATE[2:0];
                           rsp_ff.send_host_port  <= rd_ff.hv_port;
                           rsp_ff.send_guest_port <= rd_ff.vm_port;
                           rsp_ff.send_fwd_cnt    <= rd_ff.rx_count;
                           rsp_ff.send_buf_alloc  <= adv_buffer_ff;
                        end
                     end
                     PK_SHUTDOWN, PK_RST: begin
                        if (hit_ff) begin
                           if (req_ff.pkt_op == PK_SHUTDOWN) begin
                              rsp_ff.send_valid      <= 1'b1;
                              rsp_ff.send_op         <= PK_RST[2:0];
                              rsp_ff.send_host_port  <= rd_ff.hv_port;
                              rsp_ff.send_guest_port <= rd_ff.vm_port;
                              rsp_ff.send_buf_alloc  <= adv_buffer_ff;
                           end
                           used_ff[hit_idx_ff] <= 1'b0;
                           rsp_ff.host_action  <= ACT_CLOSE;
                        end
                     end
                     default: begin
                     end
                  endcase
               end else if (req_ff.op == OP_HDATA) begin
                  if (hit_ff && !phase_ff[hit_idx_ff] && chunk != 32'd0) begin
                     rsp_ff.send_valid      <= 1'b1;
                     rsp_ff.send_op         <= PK_DATA[2:0];
                     rsp_ff.send_host_port  <= rd_ff.hv_port;
                     rsp_ff.send_guest_port <= rd_ff.vm_port;
                     rsp_ff.send_len        <= chunk[11:0];
                     rsp_ff.send_fwd_cnt    <= rd_ff.rx_count;
                     rsp_ff.send_buf_alloc  <= adv_buffer_ff;
                     rsp_ff.host_action     <= ACT_READ;
                     rsp_ff.host_len        <= chunk;
                     mem[hit_idx_ff] <= '{vm_port: rd_ff.vm_port,
                                          hv_port: rd_ff.hv_port,
                                          rx_count: rd_ff.rx_count,
                                          tx_count: rd_ff.tx_count + chunk,
                                          peer_buffer: rd_ff.peer_buffer,
                                          peer_forwarded: rd_ff.peer_forwarded};
                  end
               end else if (req_ff.op == OP_HCLOSE) begin
                  if (hit_ff && !phase_ff[hit_idx_ff]) begin
                     rsp_ff.send_valid      <= 1'b1;
                     rsp_ff.send_op         <= PK_SHUTDOWN[2:0];
                     rsp_ff.send_host_port  <= rd_ff.hv_port;
                     rsp_ff.send_guest_port <= rd_ff.vm_port;
                     rsp_ff.send_flags      <= 2'b11;
                     rsp_ff.send_fwd_cnt    <= rd_ff.rx_count;
                     rsp_ff.send_buf_alloc  <= adv_buffer_ff;
                     used_ff[hit_idx_ff]    <= 1'b0;
                     rsp_ff.host_action     <= ACT_CLOSE;
                  end
               end else begin
                  if (!free_ff) begin
                     rsp_ff.host_action <= ACT_CLOSE;
                  end else begin
                     used_ff[free_idx_ff]   <= 1'b1;
                     phase_ff[free_idx_ff]  <= 1'b1;
                     next_hp_ff             <= next_hp_ff + 32'd1;
                     mem[free_idx_ff] <= '{vm_port: req_ff.vm_port,
                                          hv_port: next_hp_ff,
                                          rx_count: 32'd0, tx_count: 32'd0,
                                          peer_buffer: 32'd0, peer_forwarded: 32'd0};
                     rsp_ff.send_valid      <= 1'b1;
                     rsp_ff.send_op         <= PK_REQUEST[2:0];
                     rsp_ff.send_host_port  <= next_hp_ff;
                     rsp_ff.send_guest_port <= req_ff.vm_port;
                     rsp_ff.send_buf_alloc  <= adv_buffer_ff;
                  end
               end
            end
            S_OUT: begin
               if (rsp_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: dv/tb_vsock_connection_table_top.sv
// ============================================================================
// tb_vsock_connection_table_top: self-checking bench for the connection table
// Drives guest packets and host events through the request channel, predicts
// every response with an internal model of the table, and compares field by
// field. Covers allocation, table full, credit limits and register changes.
// ============================================================================
module tb_vsock_connection_table_top;
   timeunit 1ns;
   timeprecision 1ps;
   import vct_pkg::*;

   localparam logic [1:0] OP_HCONNECT = 2'd3;
   localparam logic [2:0] ADDR_MAX_PAYLOAD = 3'd0;
   localparam logic [2:0] ADDR_ADV_BUFFER  = 3'd4;
   localparam int unsigned StallLimit = 20000;

   class conn_scoreboard;
      bit          used [MaxConnections];
      bit          connecting [MaxConnections];
      logic [31:0] gport [MaxConnections];
      logic [31:0] hport [MaxConnections];
      logic [31:0] rx_bytes [MaxConnections];
      logic [31:0] tx_bytes [MaxConnections];
      logic [31:0] peer_buf [MaxConnections];
      logic [31:0] peer_fwd [MaxConnections];
      logic [31:0] next_port;
      logic [11:0] payload_limit;
      logic [31:0] adv_buffer;
      rsp_type     pending_rsp [$];
      int          mismatches;

      function new();
         next_port = FirstHostPort;
         payload_limit = PayloadCap;
         adv_buffer = BufReset;
         foreach (used[i]) used[i] = 1'b0;
      endfunction

      function int find_conn(logic [31:0] gp, logic [31:0] hp);
         for (int i = 0; i < MaxConnections; i++)
            if (used[i] && gport[i] == gp && hport[i] == hp) return i;
         return -1;
      endfunction

      function int find_free();
         for (int i = 0; i < MaxConnections; i++)
            if (!used[i]) return i;
         return -1;
      endfunction

      function void set_packet(ref rsp_type r, input logic [15:0] opc, logic [31:0] hp,
                               logic [31:0] gp, logic [11:0] plen, logic [1:0] flags,
                               logic [31:0] fwd);
         r.send_valid = 1'b1;
         r.send_op = opc[2:0];
         r.send_host_port = hp;
         r.send_guest_port = gp;
         r.send_len = plen;
         r.send_flags = flags;
         r.send_fwd_cnt = fwd;
         r.send_buf_alloc = adv_buffer;
      endfunction

      function void note_request(req_type q);
         rsp_type r;
         int c;
         logic [31:0] inflight, credit, chunk;
         logic [11:0] lim;
         r = '0;
         c = -1;
         if (q.op != OP_HCONNECT) c = find_conn(q.vm_port, q.hv_port);
         if (q.op == OP_GUEST) begin
            if (c >= 0) begin
               peer_buf[c] = q.rx_buf_size;
               peer_fwd[c] = q.fwd_cnt;
            end
            case (q.pkt_op)
               PK_REQUEST: begin
                  if (c < 0) begin
                     c = find_free();
                     if (c < 0 || !q.host_ok) begin
                        set_packet(r, PK_RST, q.hv_port, q.vm_port, '0, '0, '0);
                     end else begin
                        used[c] = 1'b1;
                        connecting[c] = 1'b0;
                        gport[c] = q.vm_port;
                        hport[c] = q.hv_port;
                        rx_bytes[c] = '0;
                        tx_bytes[c] = '0;
                        peer_buf[c] = q.rx_buf_size;
                        peer_fwd[c] = q.fwd_cnt;
                        set_packet(r, PK_RESPONSE, q.hv_port, q.vm_port, '0, '0, '0);
                     end
                  end
               end
               PK_RESPONSE: begin
                  if (c >= 0 && connecting[c]) begin
                     connecting[c] = 1'b0;
                     r.host_action = ACT_OK;
                  end
               end
               PK_DATA: begin
                  if (c < 0) begin
                     set_packet(r, PK_RST, q.hv_port, q.vm_port, '0, '0, '0);
                  end else begin
                     r.host_action = ACT_WRITE;
                     r.host_len = q.len;
                     rx_bytes[c] = rx_bytes[c] + q.len;
                     set_packet(r, PK_CREDIT_UPDATE, hport[c], gport[c], '0, '0, rx_bytes[c]);
                  end
               end
               PK_CREDIT_REQUEST: begin
                  if (c >= 0)
                     set_packet(r, PK_CREDIT_UPDATE, hport[c], gport[c], '0, '0, rx_bytes[c]);
               end
               PK_SHUTDOWN, PK_RST: begin
                  if (c >= 0) begin
                     if (q.pkt_op == PK_SHUTDOWN)
                        set_packet(r, PK_RST, hport[c], gport[c], '0, '0, '0);
                     used[c] = 1'b0;
                     r.host_action = ACT_CLOSE;
                  end
               end
               default: ;
            endcase
         end else if (q.op == OP_HDATA) begin
            if (c >= 0 && !connecting[c]) begin
               lim = (payload_limit > PayloadCap) ? PayloadCap : payload_limit;
               inflight = tx_bytes[c] - peer_fwd[c];
               credit = (peer_buf[c] > inflight) ? peer_buf[c] - inflight : 32'd0;
               chunk = {20'd0, q.host_bytes};
               if (chunk > credit) chunk = credit;
               if (chunk > {20'd0, lim}) chunk = {20'd0, lim};
               if (chunk != 0) begin
                  set_packet(r, PK_DATA, hport[c], gport[c], chunk[11:0], '0, rx_bytes[c]);
                  tx_bytes[c] = tx_bytes[c] + chunk;
                  r.host_action = ACT_READ;
                  r.host_len = chunk;
               end
            end
         end else if (q.op == OP_HCLOSE) begin
            if (c >= 0 && !connecting[c]) begin
               set_packet(r, PK_SHUTDOWN, hport[c], gport[c], '0, 2'd3, rx_bytes[c]);
               used[c] = 1'b0;
               r.host_action = ACT_CLOSE;
            end
         end else begin
            c = find_free();
            if (c < 0) begin
               r.host_action = ACT_CLOSE;
            end else begin
               used[c] = 1'b1;
               connecting[c] = 1'b1;
               gport[c] = q.vm_port;
               hport[c] = next_port;
               rx_bytes[c] = '0;
               tx_bytes[c] = '0;
               peer_buf[c] = '0;
               peer_fwd[c] = '0;
               set_packet(r, PK_REQUEST, next_port, q.vm_port, '0, '0, '0);
               next_port = next_port + 32'd1;
            end
         end
         pending_rsp.push_back(r);
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
            return;
         end
         exp = pending_rsp.pop_front();
         if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response mismatch: valid %b/%b op %0d/%0d hp %0d/%0d gp %0d/%0d",
                        exp.send_valid, got.send_valid, exp.send_op, got.send_op,
                        exp.send_host_port, got.send_host_port,
                        exp.send_guest_port, got.send_guest_port);
               $display("  len %0d/%0d flags %0d/%0d fwd %0d/%0d buf %0d/%0d",
                        exp.send_len, got.send_len, exp.send_flags, got.send_flags,
                        exp.send_fwd_cnt, got.send_fwd_cnt,
                        exp.send_buf_alloc, got.send_buf_alloc);
               $display("  action %0d/%0d host_len %0d/%0d", exp.host_action,
                        got.host_action, exp.host_len, got.host_len);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   conn_scoreboard sb;
   int  send_idle_pct;
   int  recv_idle_pct;
   bit  hold_rsp;
   int  idle_cycles;

   vsock_connection_table_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         rsp_ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("tb_vsock_connection_table_top: FAIL");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_MAX_PAYLOAD) sb.payload_limit = value[11:0];
      else sb.adv_buffer = value;
      @(posedge clock);
   endtask

   task automatic send_request(req_type q);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock iff (req_valid && req_ready));
      sb.note_request(q);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic req_type make_req(logic [1:0] op, logic [15:0] pop, logic [31:0] gp,
                                        logic [31:0] hp);
      req_type q;
      q.op = op;
      q.pkt_op = pop;
      q.vm_port = gp;
      q.hv_port = hp;
      q.len = $urandom;
      q.rx_buf_size = $urandom_range(8000);
      q.fwd_cnt = $urandom_range(3000);
      q.host_ok = 1'b1;
      q.host_bytes = 12'($urandom_range(4000));
      return q;
   endfunction

   // Mostly traffic on a small set of live connections, with some noise.
   function automatic req_type random_req();
      req_type q;
      int k, r;
      logic [15:0] pops [7];
      pops = '{PK_REQUEST, PK_RESPONSE, PK_RST, PK_SHUTDOWN, PK_DATA,
               PK_CREDIT_UPDATE, PK_CREDIT_REQUEST};
      q = make_req(OP_GUEST, pops[$urandom_range(6)], $urandom_range(7), $urandom_range(7));
      r = $urandom_range(99);
      k = $urandom_range(MaxConnections - 1);
      if (r < 70 && sb.used[k]) begin
         q.vm_port = sb.gport[k];
         q.hv_port = sb.hport[k];
         if ($urandom_range(9) == 0) q.op = OP_HCLOSE;
         else if ($urandom_range(2) == 0) q.op = OP_HDATA;
         else q.op = OP_GUEST;
         if ($urandom_range(5) == 0) q.pkt_op = PK_RESPONSE;
      end else if (r < 82) begin
         q.pkt_op = PK_REQUEST;
         q.host_ok = ($urandom_range(9) != 0);
         if ($urandom_range(9) == 0) q.vm_port = $urandom;
      end else if (r < 88) begin
         q.op = OP_HCONNECT;
      end else if (r < 94) begin
         q.pkt_op = 16'($urandom);
         q.hv_port = $urandom;
         q.host_ok = 1'($urandom);
      end
      if ($urandom_range(19) == 0) q.rx_buf_size = $urandom;
      if ($urandom_range(19) == 0) q.fwd_cnt = $urandom;
      if ($urandom_range(3) == 0) q.len = $urandom_range(5000);
      return q;
   endfunction

   initial begin
      req_type q;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      hold_rsp = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part.
      csr_write(ADDR_MAX_PAYLOAD, 32'd4095);
      csr_write(ADDR_ADV_BUFFER, 32'hFFFF_FFFF);
      q = make_req(OP_GUEST, PK_REQUEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      q.rx_buf_size = 32'hFFFF_FFFF; q.fwd_cnt = 0;
      send_request(q);
      send_request(q);                                      // duplicate request
      q.host_bytes = 12'hFFF; q.op = OP_HDATA;
      send_request(q);
      q = make_req(OP_GUEST, PK_DATA, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      q.len = 32'hFFFF_FFFF;
      send_request(q);
      q.len = 2;
      send_request(q);                                      // receive count wraps
      q.pkt_op = PK_CREDIT_REQUEST; send_request(q);
      q.pkt_op = PK_CREDIT_UPDATE; q.rx_buf_size = 0; send_request(q);
      q.op = OP_HDATA; send_request(q);                     // no credit: nothing sent
      q.op = OP_HCLOSE; send_request(q);
      q = make_req(OP_GUEST, PK_DATA, 0, 0); send_request(q);  // data without entry
      q.pkt_op = PK_SHUTDOWN; send_request(q);
      q.pkt_op = 16'hFFFF; send_request(q);
      q = make_req(OP_GUEST, PK_REQUEST, 5, 6); q.host_ok = 0; send_request(q);
      q.host_ok = 1; send_request(q);
      q.pkt_op = PK_RESPONSE; send_request(q);              // ignored: already open
      q.pkt_op = PK_SHUTDOWN; send_request(q);
      q = make_req(OP_HCONNECT, 0, 1234, 0); send_request(q);
      q = make_req(OP_HCLOSE, 0, 1234, FirstHostPort); send_request(q);  // connecting
      q = make_req(OP_GUEST, PK_RESPONSE, 1234, FirstHostPort); send_request(q);
      q.pkt_op = PK_RST; send_request(q);
      // Fill the table then overflow on both allocation paths.
      for (int i = 0; i < MaxConnections; i++) begin
         q = make_req(OP_HCONNECT, 0, 100 + i, 0);
         send_request(q);
      end
      q = make_req(OP_GUEST, PK_REQUEST, 9, 9); send_request(q);
      q = make_req(OP_HCONNECT, 0, 9, 0); send_request(q);
      for (int i = 0; i < MaxConnections; i++) begin
         q = make_req(OP_GUEST, PK_RST, sb.gport[i], sb.hport[i]);
         send_request(q);
      end
      // Sender pauses until every response has arrived.
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 86 : 0;
         recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 15 : 0;
         csr_write(ADDR_MAX_PAYLOAD, (phase == 0) ? 32'd0 : (phase == 1) ? 32'd1 :
                                     32'($urandom_range(1, 4000)));
         csr_write(ADDR_ADV_BUFFER, (phase == 1) ? 32'd0 : $urandom);
         for (int n = 0; n < 300; n++) begin
            if (phase == 2 && n == 100) begin
               fork
                  begin
                     hold_rsp = 1'b1;
                     repeat (400) @(posedge clock);
                     hold_rsp = 1'b0;
                  end
               join_none
            end
            send_request(random_req());
         end
         wait_drained();
      end
      if (sb.mismatches == 0)
         $display("tb_vsock_connection_table_top: PASS");
      else
         $display("tb_vsock_connection_table_top: FAIL");
      $finish;
   end
endmodule

// File: sim.f
src/vct_pkg.sv
src/vsock_connection_table_top.sv
dv/tb_vsock_connection_table_top.sv
